// ----- hw/rtl/ssc_pkg.sv -----
`timescale 1ns / 1ps

package ssc_pkg;

  // fixed field widths
  localparam int DATA_W  = 32;
  localparam int DIFF_W  = 33;
  localparam int PROD_W  = 66;
  localparam int NUM_W   = 49;
  localparam int SUM_W   = 38;
  localparam int MODE_W  = 2;
  localparam int ORDER_W = 5;
  localparam int CFG_W   = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CNT_W   = 7;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [1:0] status_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 1'b1;

  // operating modes
  localparam logic [MODE_W-1:0] MODE_INT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DIF  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_AVG  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_PASS = 2'd3;

  // result status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_ZERO  = 2'd1;
  localparam status_t ST_SAT   = 2'd2;
  localparam status_t ST_SHORT = 2'd3;

endpackage

// ----- hw/rtl/ssc_channels.sv -----
`timescale 1ns / 1ps

interface ssc_sample_if;
  logic          valid;
  logic          ready;
  ssc_pkg::data_t x_value;
  ssc_pkg::data_t y_value;
  logic          series_end;
  modport source(output valid, x_value, y_value, series_end, input ready);
  modport sink(input valid, x_value, y_value, series_end, output ready);
endinterface

interface ssc_result_if;
  logic             valid;
  logic             ready;
  ssc_pkg::data_t   result_value;
  logic             result_last;
  ssc_pkg::status_t status;
  modport source(output valid, result_value, result_last, status, input ready);
  modport sink(input valid, result_value, result_last, status, output ready);
endinterface

// ----- hw/rtl/ssc_mul.sv -----
`timescale 1ns / 1ps

module ssc_mul (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [ssc_pkg::DIFF_W-1:0]         a,
  input  logic [ssc_pkg::DIFF_W-1:0]         b,
  output logic                               done,
  output logic [ssc_pkg::PROD_W-1:0]         prod
);

  localparam int W = ssc_pkg::DIFF_W;

  logic [W-1:0]                   a_r;
  logic [ssc_pkg::PROD_W-1:0]     p;
  logic [ssc_pkg::CNT_W-1:0]      cnt;
  logic                           busy;
  logic [W:0]                     part;

  // one multiplier bit per cycle: add then shift right
  assign part = {1'b0, p[2*W-1:W]} + (p[0] ? {1'b0, a_r} : {(W+1){1'b0}});
  assign prod = p;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r  <= a;
        p    <= {{W{1'b0}}, b};
        cnt  <= ssc_pkg::CNT_W'(W);
        busy <= 1'b1;
      end else if (busy) begin
        p   <= {part, p[W-1:1]};
        cnt <= cnt - 1'b1;
        if (cnt == ssc_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/ssc_div.sv -----
`timescale 1ns / 1ps

module ssc_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ssc_pkg::NUM_W-1:0]    num,
  input  logic [ssc_pkg::DIFF_W-1:0]   den,
  output logic                         done,
  output logic [ssc_pkg::NUM_W-1:0]    quot
);

  localparam int NW = ssc_pkg::NUM_W;
  localparam int DW = ssc_pkg::DIFF_W;

  logic [NW-1:0]              q;
  logic [DW-1:0]              den_r;
  logic [DW-1:0]              rem;
  logic [ssc_pkg::CNT_W-1:0]  cnt;
  logic                       busy;
  logic [DW:0]                trial;
  logic                       fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, q[NW-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign quot  = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q     <= num;
        den_r <= den;
        rem   <= '0;
        cnt   <= ssc_pkg::CNT_W'(NW);
        busy  <= 1'b1;
      end else if (busy) begin
        rem <= fits ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
        q   <= {q[NW-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == ssc_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/sample_series_calculus_top.sv -----
`timescale 1ns / 1ps

// Streaming calculus over a series of signed Q16.16 (x, y) samples.
// sample_in takes one sample per transaction; series_end marks the last one.
// result_out gives result transactions in sample order; result_last marks the
// result of the final sample. cfg_we/cfg_index/cfg_data write mode (index 0)
// and average order (index 1); any write restarts the series.
// One sample is worked at a time; sample_in.ready is high only when idle.
// Work per sample, set by the bit-serial multiplier and divider:
//   integrate: 33-bit shift-add multiplier plus accumulate
//   derivative: 49-bit restoring divider, run once more for the
//   second result at the end of a series
//   moving average: reads of 2K+1 history entries plus the divide,
//   plus a history read per flushed result at the end of a series
// A finished result sits in the output register, so a stalled receiver only
// holds the block when the next result is ready to go out.
// Reset clears the series, sets mode 0 and order 1; the history memory
// needs no clearing since only samples of the current series are read.
module sample_series_calculus_top #(
  parameter int MAX_ORDER  = 16,
  parameter int MAX_POINTS = 65536
) (
  input  logic                                clk,
  input  logic                                rst,
  ssc_sample_if.sink                          sample_in,
  ssc_result_if.source                        result_out,
  input  logic                                cfg_we,
  input  logic [ssc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ssc_pkg::CFG_W-1:0]           cfg_data
);

  localparam int HD = 2 * MAX_ORDER + 1;
  localparam int AW = $clog2(HD);
  localparam int KW = $clog2(MAX_ORDER + 1);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int EW = CW + KW + 4;
  localparam int DW = ssc_pkg::DIFF_W;
  localparam int SW = ssc_pkg::SUM_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_ACC  = 4'd3;
  localparam logic [3:0] S_DSTA = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_SUMA = 4'd6;
  localparam logic [3:0] S_SUMW = 4'd7;
  localparam logic [3:0] S_SDIV = 4'd8;
  localparam logic [3:0] S_RAWA = 4'd9;
  localparam logic [3:0] S_RAWW = 4'd10;
  localparam logic [3:0] S_FL0  = 4'd11;
  localparam logic [3:0] S_FLA  = 4'd12;
  localparam logic [3:0] S_FLW  = 4'd13;
  localparam logic [3:0] S_EMIT = 4'd14;
  localparam logic [3:0] S_DONE = 4'd15;

  logic [3:0]                     state;
  logic [ssc_pkg::MODE_W-1:0]     mode_r;
  logic [ssc_pkg::ORDER_W-1:0]    order_r;
  logic [CW-1:0]                  count;
  logic [CW-1:0]                  n_r;
  logic signed [63:0]             integ;
  ssc_pkg::data_t                 x_r, y_r, xp1, xp2, yp1, yp2;
  logic                           end_r;
  logic                           ph;
  logic                           neg_r;
  logic [AW-1:0]                  idx;
  logic [AW-1:0]                  wptr;
  logic [AW-1:0]                  raddr;
  logic signed [SW-1:0]           sum;
  ssc_pkg::data_t                 mem [2**AW];
  ssc_pkg::data_t                 rdata;

  // pending result and output register
  ssc_pkg::data_t                 em_value;
  logic                           em_last;
  ssc_pkg::status_t               em_status;
  logic [3:0]                     em_ret;
  logic                           ov;
  ssc_pkg::data_t                 o_value;
  logic                           o_last;
  ssc_pkg::status_t               o_status;

  // arithmetic units
  logic                           mul_go, mul_done;
  logic [DW-1:0]                  op_a, op_b;
  logic [ssc_pkg::PROD_W-1:0]     prod;
  logic                           div_go, div_done;
  logic [ssc_pkg::NUM_W-1:0]      div_num, quot;
  logic [DW-1:0]                  div_den;

  logic                           accept;
  logic [KW-1:0]                  kk;
  logic [AW-1:0]                  kk_a, kk2_a, flush_start;
  logic [EW-1:0]                  n_e, kk_e;
  logic                           n_ge_k, n_ge_2k, short_avg;
  logic signed [DW-1:0]           dx1, ys, dx_sel, dy_sel;
  logic [DW-1:0]                  dx1_mag, ys_mag, dx_mag, dy_mag;
  logic [SW-1:0]                  sum_mag;
  logic [ssc_pkg::NUM_W-1:0]      area_m;
  logic signed [63:0]             area, integ_next;
  logic signed [64:0]             acc_wide;
  ssc_pkg::data_t                 int_out;
  logic                           int_sat;
  logic                           use_far;
  logic [3:0]                     dif_ret;
  ssc_pkg::data_t                 dif_value;
  ssc_pkg::status_t               dif_status;
  logic [ssc_pkg::NUM_W-1:0]      q_neg;

  assign accept = sample_in.valid && sample_in.ready;
  assign sample_in.ready = (state == S_IDLE);

  assign result_out.valid        = ov;
  assign result_out.result_value = o_value;
  assign result_out.result_last  = o_last;
  assign result_out.status       = o_status;

  // effective half window
  always_comb begin
    if (order_r == '0) begin
      kk = KW'(1);
    end else if (int'(order_r) > MAX_ORDER) begin
      kk = KW'(MAX_ORDER);
    end else begin
      kk = KW'(order_r);
    end
  end

  assign kk_a        = AW'(kk);
  assign kk2_a       = AW'({kk_a, 1'b0});
  assign n_e         = EW'(n_r);
  assign kk_e        = EW'(kk);
  assign n_ge_k      = n_e >= kk_e;
  assign n_ge_2k     = n_e >= (kk_e << 1);
  assign short_avg   = (n_e + EW'(1)) < (kk_e << 3);
  assign flush_start = n_ge_k ? AW'(kk - KW'(1)) : AW'(n_r);
  assign raddr       = wptr - AW'(1) - idx;

  // trapezoid operands
  assign dx1     = {x_r[31], x_r} - {xp1[31], xp1};
  assign ys      = {y_r[31], y_r} + {yp1[31], yp1};
  assign dx1_mag = dx1[DW-1] ? DW'(-dx1) : DW'(dx1);
  assign ys_mag  = ys[DW-1] ? DW'(-ys) : DW'(ys);

  // difference operands: central step inside the series, else adjacent
  assign use_far = !ph && (n_r >= CW'(2));
  assign dx_sel  = {x_r[31], x_r} - (use_far ? {xp2[31], xp2} : {xp1[31], xp1});
  assign dy_sel  = {y_r[31], y_r} - (use_far ? {yp2[31], yp2} : {yp1[31], yp1});
  assign dx_mag  = dx_sel[DW-1] ? DW'(-dx_sel) : DW'(dx_sel);
  assign dy_mag  = dy_sel[DW-1] ? DW'(-dy_sel) : DW'(dy_sel);
  assign sum_mag = sum[SW-1] ? SW'(-sum) : SW'(sum);
  assign dif_ret = (!ph && end_r) ? S_DSTA : S_DONE;

  // saturating accumulate of one trapezoid
  assign area_m     = prod[ssc_pkg::PROD_W-1:17];
  assign area       = neg_r ? -{15'b0, area_m} : {15'b0, area_m};
  assign acc_wide   = {integ[63], integ} + {area[63], area};
  always_comb begin
    if (acc_wide[64] != acc_wide[63]) begin
      integ_next = acc_wide[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end else begin
      integ_next = acc_wide[63:0];
    end
    int_sat = (integ_next[63:31] != {33{integ_next[63]}});
    if (int_sat) begin
      int_out = integ_next[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      int_out = integ_next[31:0];
    end
  end

  // quotient to signed Q16.16 with saturation
  assign q_neg = -quot;
  always_comb begin
    dif_status = ssc_pkg::ST_OK;
    if (!neg_r && quot > ssc_pkg::NUM_W'(32'h7fff_ffff)) begin
      dif_value  = 32'sh7fff_ffff;
      dif_status = ssc_pkg::ST_SAT;
    end else if (neg_r && quot > ssc_pkg::NUM_W'(32'h8000_0000)) begin
      dif_value  = 32'sh8000_0000;
      dif_status = ssc_pkg::ST_SAT;
    end else begin
      dif_value  = neg_r ? q_neg[31:0] : quot[31:0];
    end
  end

  ssc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_go),
    .a     (op_a),
    .b     (op_b),
    .done  (mul_done),
    .prod  (prod)
  );

  ssc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  // y history memory, newest at wptr - 1
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wptr] <= sample_in.y_value;
    end
    rdata <= mem[raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      mode_r  <= ssc_pkg::MODE_INT;
      order_r <= ssc_pkg::ORDER_W'(1);
      count   <= '0;
      integ   <= '0;
      ov      <= 1'b0;
      mul_go  <= 1'b0;
      div_go  <= 1'b0;
      wptr    <= '0;
    end else begin
      mul_go <= 1'b0;
      div_go <= 1'b0;
      if (ov && result_out.ready) begin
        ov <= 1'b0;
      end
      if (cfg_we) begin
        if (cfg_index == ssc_pkg::CFG_MODE) begin
          mode_r <= cfg_data[ssc_pkg::MODE_W-1:0];
        end else begin
          order_r <= cfg_data[ssc_pkg::ORDER_W-1:0];
        end
        count <= '0;
        integ <= '0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            x_r   <= sample_in.x_value;
            y_r   <= sample_in.y_value;
            end_r <= sample_in.series_end;
            n_r   <= count;
            wptr  <= wptr + AW'(1);
            if (sample_in.series_end) begin
              count <= '0;
            end else if (count < CW'(MAX_POINTS)) begin
              count <= count + CW'(1);
            end
            state <= S_DISP;
          end
        end
        S_DISP: begin
          unique case (mode_r)
            ssc_pkg::MODE_INT: begin
              if (n_r == '0) begin
                integ     <= '0;
                em_value  <= '0;
                em_last   <= end_r;
                em_status <= end_r ? ssc_pkg::ST_SHORT : ssc_pkg::ST_OK;
                em_ret    <= S_DONE;
                state     <= S_EMIT;
              end else begin
                op_a   <= dx1_mag;
                op_b   <= ys_mag;
                neg_r  <= dx1[DW-1] != ys[DW-1];
                mul_go <= 1'b1;
                state  <= S_MUL;
              end
            end
            ssc_pkg::MODE_DIF: begin
              ph <= 1'b0;
              if (n_r != '0) begin
                state <= S_DSTA;
              end else if (end_r) begin
                em_value  <= '0;
                em_last   <= 1'b1;
                em_status <= ssc_pkg::ST_SHORT;
                em_ret    <= S_DONE;
                state     <= S_EMIT;
              end else begin
                state <= S_DONE;
              end
            end
            ssc_pkg::MODE_AVG: begin
              if (n_ge_2k) begin
                idx   <= '0;
                sum   <= '0;
                state <= S_SUMA;
              end else if (n_ge_k) begin
                idx   <= kk_a;
                state <= S_RAWA;
              end else begin
                state <= S_FL0;
              end
            end
            ssc_pkg::MODE_PASS: begin
              em_value  <= y_r;
              em_last   <= end_r;
              em_status <= ssc_pkg::ST_OK;
              em_ret    <= S_DONE;
              state     <= S_EMIT;
            end
          endcase
        end
        S_MUL: begin
          if (mul_done) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          integ     <= integ_next;
          em_value  <= int_out;
          em_last   <= end_r;
          em_status <= int_sat ? ssc_pkg::ST_SAT : ssc_pkg::ST_OK;
          em_ret    <= S_DONE;
          state     <= S_EMIT;
        end
        S_DSTA: begin
          if (dx_sel == '0) begin
            em_value  <= '0;
            em_last   <= ph;
            em_status <= ssc_pkg::ST_ZERO;
            em_ret    <= dif_ret;
            ph        <= 1'b1;
            state     <= S_EMIT;
          end else begin
            div_num <= {dy_mag, 16'b0};
            div_den <= dx_mag;
            neg_r   <= dy_sel[DW-1] != dx_sel[DW-1];
            div_go  <= 1'b1;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (mode_r == ssc_pkg::MODE_AVG) begin
              em_value  <= neg_r ? q_neg[31:0] : quot[31:0];
              em_last   <= 1'b0;
              em_status <= ssc_pkg::ST_OK;
              em_ret    <= S_FL0;
            end else begin
              em_value  <= dif_value;
              em_last   <= ph;
              em_status <= dif_status;
              em_ret    <= dif_ret;
              ph        <= 1'b1;
            end
            state <= S_EMIT;
          end
        end
        S_SUMA: begin
          state <= S_SUMW;
        end
        S_SUMW: begin
          // neighbor sum, centre sample left out
          if (idx != kk_a) begin
            sum <= sum + SW'(rdata);
          end
          if (idx == kk2_a) begin
            state <= S_SDIV;
          end else begin
            idx   <= idx + AW'(1);
            state <= S_SUMA;
          end
        end
        S_SDIV: begin
          div_num <= ssc_pkg::NUM_W'(sum_mag);
          div_den <= DW'(kk2_a);
          neg_r   <= sum[SW-1];
          div_go  <= 1'b1;
          state   <= S_DIV;
        end
        S_RAWA: begin
          state <= S_RAWW;
        end
        S_RAWW: begin
          em_value  <= rdata;
          em_last   <= 1'b0;
          em_status <= ssc_pkg::ST_OK;
          em_ret    <= S_FL0;
          state     <= S_EMIT;
        end
        S_FL0: begin
          if (end_r) begin
            idx   <= flush_start;
            state <= S_FLA;
          end else begin
            state <= S_DONE;
          end
        end
        S_FLA: begin
          state <= S_FLW;
        end
        S_FLW: begin
          // pending edge results, oldest first
          em_value  <= rdata;
          em_last   <= (idx == '0);
          em_status <= (idx == '0 && short_avg) ? ssc_pkg::ST_SHORT : ssc_pkg::ST_OK;
          em_ret    <= (idx == '0) ? S_DONE : S_FLA;
          idx       <= idx - AW'(1);
          state     <= S_EMIT;
        end
        S_EMIT: begin
          if (!ov || result_out.ready) begin
            ov       <= 1'b1;
            o_value  <= em_value;
            o_last   <= em_last;
            o_status <= em_status;
            state    <= em_ret;
          end
        end
        S_DONE: begin
          xp2 <= xp1;
          xp1 <= x_r;
          yp2 <= yp1;
          yp1 <= y_r;
          if (end_r) begin
            integ <= '0;
          end
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- test/sample_series_calculus_top_test.sv -----
`timescale 1ns / 1ps

module sample_series_calculus_top_test;

  localparam int HIST_DEPTH   = 33;
  localparam int ORDER_LIMIT  = 16;
  localparam int POINT_LIMIT  = 65536;
  localparam int RANDOM_ITEMS = 320;
  localparam int SETTLE_CYCLES = 300;
  localparam int STALL_LIMIT  = 5000;

  typedef struct packed {
    ssc_pkg::data_t   value;
    logic             last;
    ssc_pkg::status_t status;
  } result_t;

  typedef struct {
    logic [ssc_pkg::MODE_W-1:0]  mode;
    logic [ssc_pkg::ORDER_W-1:0] order;
    ssc_pkg::data_t              x;
    ssc_pkg::data_t              y;
    logic                        last;
    logic                        typed;
    ssc_pkg::data_t              want_value;
    ssc_pkg::status_t            want_status;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [ssc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ssc_pkg::CFG_W-1:0] cfg_data;

  ssc_sample_if sample_if();
  ssc_result_if result_if();

  sample_series_calculus_top dut (
    .clk(clk),
    .rst(rst),
    .sample_in(sample_if),
    .result_out(result_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [ssc_pkg::MODE_W-1:0]  cur_mode;
  logic [ssc_pkg::ORDER_W-1:0] cur_order;
  longint y_hist [HIST_DEPTH];
  longint x_hist [2];
  int     sample_pos;
  longint integral_acc;

  result_t pending_results[$];
  bit      failed;
  int      burst_left;
  int      idle_cycles;

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic void clear_series();
    foreach (y_hist[i]) y_hist[i] = 0;
    x_hist[0] = 0;
    x_hist[1] = 0;
    sample_pos = 0;
    integral_acc = 0;
  endfunction

  function automatic ssc_pkg::data_t slope_q16(longint dy, longint dx,
                                               output ssc_pkg::status_t st);
    longint unsigned q;
    bit neg;
    st = ssc_pkg::ST_OK;
    if (dx == 0) begin
      st = ssc_pkg::ST_ZERO;
      return '0;
    end
    q = (magnitude(dy) << 16) / magnitude(dx);
    neg = (dy < 0) != (dx < 0);
    if (!neg && q > 64'h7fffffff) begin
      st = ssc_pkg::ST_SAT;
      return 32'h7fffffff;
    end
    if (neg && q > 64'h80000000) begin
      st = ssc_pkg::ST_SAT;
      return 32'h80000000;
    end
    return neg ? ssc_pkg::data_t'(64'd0 - q) : ssc_pkg::data_t'(q);
  endfunction

  // expected results for one accepted sample
  function automatic void predict_sample(ssc_pkg::data_t x, ssc_pkg::data_t y, logic last,
                                         ref result_t outq[$]);
    longint xv, yv, dx, ysum, area, wsum;
    longint unsigned m;
    int n, kk, c, first;
    ssc_pkg::status_t st;
    ssc_pkg::data_t v;
    xv = x;
    yv = y;
    n = sample_pos;
    for (int i = HIST_DEPTH - 1; i > 0; i--) y_hist[i] = y_hist[i-1];
    y_hist[0] = yv;
    case (cur_mode)
      ssc_pkg::MODE_INT: begin
        if (n == 0) begin
          integral_acc = 0;
        end else begin
          dx = xv - x_hist[0];
          ysum = yv + y_hist[1];
          m = (magnitude(dx) * magnitude(ysum)) >> 17;
          area = ((dx < 0) != (ysum < 0)) ? -longint'(m) : longint'(m);
          if (area > 0 && integral_acc > 64'sh7fffffffffffffff - area)
            integral_acc = 64'sh7fffffffffffffff;
          else if (area < 0 && integral_acc < -64'sh7fffffffffffffff - 1 - area)
            integral_acc = -64'sh7fffffffffffffff - 1;
          else
            integral_acc += area;
        end
        st = ssc_pkg::ST_OK;
        if (integral_acc > 64'sh7fffffff) begin
          v = 32'h7fffffff;
          st = ssc_pkg::ST_SAT;
        end else if (integral_acc < -64'sh80000000) begin
          v = 32'h80000000;
          st = ssc_pkg::ST_SAT;
        end else begin
          v = ssc_pkg::data_t'(integral_acc);
        end
        if (last && n == 0) st = ssc_pkg::ST_SHORT;
        outq.push_back('{v, last, st});
      end
      ssc_pkg::MODE_DIF: begin
        if (n >= 1) begin
          if (n == 1) v = slope_q16(yv - y_hist[1], xv - x_hist[0], st);
          else v = slope_q16(yv - y_hist[2], xv - x_hist[1], st);
          outq.push_back('{v, 1'b0, st});
        end
        if (last) begin
          if (n == 0) begin
            outq.push_back('{32'd0, 1'b1, ssc_pkg::ST_SHORT});
          end else begin
            v = slope_q16(yv - y_hist[1], xv - x_hist[0], st);
            outq.push_back('{v, 1'b1, st});
          end
        end
      end
      ssc_pkg::MODE_AVG: begin
        kk = cur_order;
        if (kk < 1) kk = 1;
        if (kk > ORDER_LIMIT) kk = ORDER_LIMIT;
        if (n >= kk) begin
          c = n - kk;
          if (c >= kk) begin
            wsum = 0;
            for (int j = 1; j <= kk; j++) wsum += y_hist[kk-j] + y_hist[kk+j];
            m = magnitude(wsum) / (2 * kk);
            v = wsum < 0 ? ssc_pkg::data_t'(64'd0 - m) : ssc_pkg::data_t'(m);
          end else begin
            v = ssc_pkg::data_t'(y_hist[kk]);
          end
          outq.push_back('{v, 1'b0, ssc_pkg::ST_OK});
        end
        if (last) begin
          first = (n + 1 > kk) ? n - kk + 1 : 0;
          for (c = first; c <= n; c++)
            outq.push_back('{ssc_pkg::data_t'(y_hist[n-c]), c == n,
                             (c == n && n + 1 < 8 * kk) ? ssc_pkg::ST_SHORT
                                                        : ssc_pkg::ST_OK});
        end
      end
      default: outq.push_back('{y, last, ssc_pkg::ST_OK});
    endcase
    x_hist[1] = x_hist[0];
    x_hist[0] = xv;
    if (sample_pos < POINT_LIMIT) sample_pos++;
    if (last) clear_series();
  endfunction

  // receiver stall pattern, style set by the top bits of a free-running counter
  logic [8:0] stall_cnt;
  always @(posedge clk) begin
    if (rst) begin
      stall_cnt <= '0;
      result_if.ready <= 1'b0;
    end else begin
      stall_cnt <= stall_cnt + 1'b1;
      case (stall_cnt[8:7])
        2'd0: result_if.ready <= 1'b1;
        2'd1: result_if.ready <= 1'($urandom_range(0, 1));
        2'd2: result_if.ready <= ($urandom_range(0, 7) == 0);
        default: result_if.ready <= stall_cnt[2];
      endcase
    end
  end

  // result checking against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: value %h last %b status %0d",
               result_if.result_value, result_if.result_last, result_if.status);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (result_if.result_value !== want.value) begin
          $error("result_value: expected %h, got %h", want.value, result_if.result_value);
          failed = 1'b1;
        end
        if (result_if.result_last !== want.last) begin
          $error("result_last: expected %b, got %b", want.last, result_if.result_last);
          failed = 1'b1;
        end
        if (result_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result_if.status);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (sample_if.valid && sample_if.ready) ||
        (result_if.valid && result_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // drain outstanding results and let the block settle
  task automatic wait_idle();
    sample_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [ssc_pkg::CFG_IDX_W-1:0] idx,
                           logic [ssc_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ssc_pkg::CFG_MODE) cur_mode = val[ssc_pkg::MODE_W-1:0];
    else cur_order = val[ssc_pkg::ORDER_W-1:0];
    clear_series();
  endtask

  task automatic apply_config(logic [ssc_pkg::MODE_W-1:0] m,
                              logic [ssc_pkg::ORDER_W-1:0] k, bit force_all);
    if (m == cur_mode && k == cur_order && !force_all) return;
    wait_idle();
    if (m != cur_mode || force_all) write_reg(ssc_pkg::CFG_MODE, ssc_pkg::CFG_W'(m));
    if (k != cur_order || force_all) write_reg(ssc_pkg::CFG_ORDER, ssc_pkg::CFG_W'(k));
  endtask

  // one sample transaction
  task automatic send_sample(ssc_pkg::data_t x, ssc_pkg::data_t y, logic last,
                             ref result_t outq[$]);
    sample_if.valid <= 1'b1;
    sample_if.x_value <= x;
    sample_if.y_value <= y;
    sample_if.series_end <= last;
    do @(posedge clk); while (!sample_if.ready);
    predict_sample(x, y, last, outq);
  endtask

  // burst gap when the burst runs out
  task automatic burst_gap();
    if (burst_left == 0) begin
      sample_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  function automatic ssc_pkg::data_t pick_y();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return ssc_pkg::data_t'($signed($urandom_range(0, 2097152)) - 1048576);
      default: return ssc_pkg::data_t'($signed($urandom_range(0, 33554432)) - 16777216);
    endcase
  endfunction

  sample_row_t directed_rows[24];

  initial begin
    result_t predicted[$];
    logic [ssc_pkg::MODE_W-1:0] rmode;
    logic [ssc_pkg::ORDER_W-1:0] rorder;
    int kk, len, sent, r;
    bit abandon;
    ssc_pkg::data_t xs, ys;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sample_if.valid = 1'b0;
    sample_if.x_value = '0;
    sample_if.y_value = '0;
    sample_if.series_end = 1'b0;
    failed = 1'b0;
    burst_left = 0;
    idle_cycles = 0;
    cur_mode = ssc_pkg::MODE_INT;
    cur_order = 5'd1;
    clear_series();

    directed_rows = '{
      // integrate: lone sample, extremes with saturation, negative and zero steps
      '{ssc_pkg::MODE_INT, 5'd1, 32'h0, 32'h7fff0000, 1'b1, 1'b1, 32'h0, ssc_pkg::ST_SHORT},
      '{ssc_pkg::MODE_INT, 5'd1, 32'h80000000, 32'h7fffffff, 1'b0, 1'b1, 32'h0,
        ssc_pkg::ST_OK},
      '{ssc_pkg::MODE_INT, 5'd1, 32'h7fffffff, 32'h7fffffff, 1'b1, 1'b1, 32'h7fffffff,
        ssc_pkg::ST_SAT},
      '{ssc_pkg::MODE_INT, 5'd1, 32'h0, 32'h00010000, 1'b0, 1'b0, 32'h0, ssc_pkg::ST_OK},
      '{ssc_pkg::MODE_INT, 5'd1, 32'h00010000, 32'h00020000, 1'b0, 1'b0, 32'h0,
        ssc_pkg::ST_OK},
      '{ssc_pkg::MODE_INT, 5'd1, 32'h0, 32'hffff0000, 1'b0, 1'b0, 32'h0, ssc_pkg::ST_OK},
      '{ssc_pkg::MODE_INT, 5'd1, 32'h0, 32'h80000000, 1'b1, 1'b0, 32'h0, ssc_pkg::ST_OK},
      // derivative: lone sample, zero steps, saturation
      '{ssc_pkg::MODE_DIF, 5'd1, 32'h1234, 32'h5678, 1'b1, 1'b1, 32'h0, ssc_pkg::ST_SHORT},
      '{ssc_pkg::MODE_DIF, 5'd1, 32'h5, 32'h00010000, 1'b0, 1'b0, 32'h0, ssc_pkg::ST_OK},
      '{ssc_pkg::MODE_DIF, 5'd1, 32'h5, 32'h00020000, 1'b1, 1'b0, 32'h0, ssc_pkg::ST_OK},
      '{ssc_pkg::MODE_DIF, 5'd1, 32'h0, 32'h80000000, 1'b0, 1'b0, 32'h0, ssc_pkg::ST_OK},
      '{ssc_pkg::MODE_DIF, 5'd1, 32'h1, 32'h7fffffff, 1'b0, 1'b0, 32'h0, ssc_pkg::ST_OK},
      '{ssc_pkg::MODE_DIF, 5'd1, 32'h2, 32'h80000000, 1'b1, 1'b0, 32'h0, ssc_pkg::ST_OK},
      '{ssc_pkg::MODE_DIF, 5'd1, 32'h00010000, 32'h00010000, 1'b0, 1'b0, 32'h0,
        ssc_pkg::ST_OK},
      '{ssc_pkg::MODE_DIF, 5'd1, 32'hffff0000, 32'hfff00000, 1'b1, 1'b0, 32'h0,
        ssc_pkg::ST_OK},
      // moving average with order 0 acting as 1
      '{ssc_pkg::MODE_AVG, 5'd0, 32'h0, 32'h00030000, 1'b0, 1'b0, 32'h0, ssc_pkg::ST_OK},
      '{ssc_pkg::MODE_AVG, 5'd0, 32'h1, 32'hfffd0000, 1'b0, 1'b0, 32'h0, ssc_pkg::ST_OK},
      '{ssc_pkg::MODE_AVG, 5'd0, 32'h2, 32'h00000007, 1'b0, 1'b0, 32'h0, ssc_pkg::ST_OK},
      '{ssc_pkg::MODE_AVG, 5'd0, 32'h3, 32'h80000000, 1'b1, 1'b0, 32'h0, ssc_pkg::ST_OK},
      // order above the maximum, short series flushed
      '{ssc_pkg::MODE_AVG, 5'd31, 32'h0, 32'h11111111, 1'b0, 1'b0, 32'h0, ssc_pkg::ST_OK},
      '{ssc_pkg::MODE_AVG, 5'd31, 32'h0, 32'h22222222, 1'b0, 1'b0, 32'h0, ssc_pkg::ST_OK},
      '{ssc_pkg::MODE_AVG, 5'd31, 32'h0, 32'h33333333, 1'b1, 1'b0, 32'h0, ssc_pkg::ST_OK},
      // unused mode passes y through
      '{ssc_pkg::MODE_PASS, 5'd16, 32'hffffffff, 32'hdeadbeef, 1'b0, 1'b1, 32'hdeadbeef,
        ssc_pkg::ST_OK},
      '{ssc_pkg::MODE_PASS, 5'd16, 32'h0, 32'h00000001, 1'b1, 1'b1, 32'h00000001,
        ssc_pkg::ST_OK}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows
    foreach (directed_rows[i]) begin
      apply_config(directed_rows[i].mode, directed_rows[i].order, 1'b0);
      predicted.delete();
      send_sample(directed_rows[i].x, directed_rows[i].y, directed_rows[i].last, predicted);
      if (directed_rows[i].typed)
        pending_results.push_back('{directed_rows[i].want_value, directed_rows[i].last,
                                    directed_rows[i].want_status});
      else
        foreach (predicted[j]) pending_results.push_back(predicted[j]);
      burst_gap();
    end

    // random series under random settings
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      rmode = (r < 3) ? ssc_pkg::MODE_INT : (r < 6) ? ssc_pkg::MODE_DIF :
              (r < 9) ? ssc_pkg::MODE_AVG : ssc_pkg::MODE_PASS;
      r = $urandom_range(0, 9);
      rorder = (r < 6) ? 5'($urandom_range(1, 3)) : (r < 8) ? 5'($urandom_range(4, 16)) :
               (r == 8) ? 5'd0 : 5'($urandom_range(17, 31));
      apply_config(rmode, rorder, $urandom_range(0, 3) == 0);
      kk = (cur_order < 1) ? 1 : (cur_order > ORDER_LIMIT) ? ORDER_LIMIT : int'(cur_order);
      repeat ($urandom_range(1, 3)) begin
        if (cur_mode == ssc_pkg::MODE_AVG) begin
          if (kk <= 3 && $urandom_range(0, 1) == 0) len = 8 * kk + $urandom_range(0, 4);
          else len = $urandom_range(1, 2 * kk + 4);
        end else begin
          len = $urandom_range(1, 12);
        end
        abandon = ($urandom_range(0, 9) == 0);
        xs = $urandom;
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 5))
            0: xs = $urandom;
            1: xs = xs;
            default: xs = xs + ssc_pkg::data_t'($urandom_range(1, 32'h40000));
          endcase
          ys = pick_y();
          predicted.delete();
          send_sample(xs, ys, (i == len - 1) && !abandon, predicted);
          foreach (predicted[j]) pending_results.push_back(predicted[j]);
          burst_gap();
          sent++;
        end
      end
    end

    wait_idle();
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/ssc_pkg.sv
hw/rtl/ssc_channels.sv
hw/rtl/ssc_mul.sv
hw/rtl/ssc_div.sv
hw/rtl/sample_series_calculus_top.sv
test/sample_series_calculus_top_test.sv
